[src/positional_array_list_macros.svh]
// assertion macros for the positional array list
// no dependencies; included by the top level only
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PLA_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// antecedent implies consequent in the next cycle
`define PLA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define PLA_ASSERT_SAME(name, clk, rst, ante, cons)
`define PLA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[src/pla_pkg.sv]
// shared types and codes of the positional array list
// no dependencies; used by the cell and the top level
package pla_pkg;

   localparam int POS_W = 4;
   localparam int DATA_W = 32;
   localparam int CNT_OUT_W = 5;
   // at most this many cells can be reached through a position field
   localparam int POS_REACH = 1 << POS_W;

   typedef enum logic [2:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_SWAP   = 3'd3,
      ACT_READ   = 3'd4
   } pla_act_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } pla_status_type;

   typedef struct packed {
      logic [2:0]               action;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         second_position;
      logic signed [DATA_W-1:0] value;
   } pla_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_OUT_W-1:0]     element_count;
      logic [1:0]               status;
   } pla_rsp_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic                     commit;
      pla_act_type              act;
      logic [POS_W-1:0]         pos;
      logic [POS_W-1:0]         pos2;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] val_a;
      logic signed [DATA_W-1:0] val_b;
   } pla_cmd_type;

endpackage

[src/pla_cell.sv]
// one storage cell of the list: holds one entry, takes from either neighbour
// depends on pla_pkg
module pla_cell import pla_pkg::*; #(
   parameter int CNT_W = 5,
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  pla_cmd_type              cmd_i,
   input  logic [CNT_W-1:0]         count_i,
   input  logic signed [DATA_W-1:0] prev_i,
   input  logic signed [DATA_W-1:0] next_i,
   output logic signed [DATA_W-1:0] entry_o
);

   localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic [CW-1:0]            idx;
   logic [CW-1:0]            p;
   logic [CW-1:0]            q;
   logic [CW-1:0]            c;

   assign idx = CW'(IDX);
   assign p   = CW'(cmd_i.pos);
   assign q   = CW'(cmd_i.pos2);
   assign c   = CW'(count_i);

   always_comb begin
      entry_in = entry_ff;
      if (cmd_i.commit) begin
         case (cmd_i.act)
            ACT_APPEND: begin
               if (idx == c) entry_in = cmd_i.value;
            end
            ACT_INSERT: begin
               if (idx == p) entry_in = cmd_i.value;
               else if (idx > p && idx <= c) entry_in = prev_i;
            end
            ACT_REMOVE: begin
               if (idx >= p && (idx + CW'(1)) < c) entry_in = next_i;
            end
            ACT_SWAP: begin
               if (idx == p) entry_in = cmd_i.val_b;
               else if (idx == q) entry_in = cmd_i.val_a;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule

[src/positional_array_list.sv]
// top level of the positional array list: control, count and a row of cells
// depends on pla_pkg, pla_cell and positional_array_list_macros.svh
//
// usage
//   request channel req_valid / req_stall / req_payload carries one action:
//   append, insert, remove, swap or read. response channel rsp_valid /
//   rsp_stall / rsp_payload returns exactly one result per request: the
//   value read (zero unless a read succeeds), the count after the request
//   and a status (ok, full, position out of range).
//   each list entry lives in its own cell; on insert every cell above the
//   position takes its lower neighbour, on remove every cell from the
//   position up takes its upper neighbour, all in the same edge.
//   the response is registered at the edge that takes the request.
//   throughput: one request per cycle while the response side keeps up;
//   set by the single output register.
//   stalling: req_stall rises while a response is held under rsp_stall,
//   so nothing is lost; the held response does not change.
//   reset: synchronous, active high; clears the count and the response
//   valid. entry contents are not cleared, only entries below the count
//   are ever read.
`include "positional_array_list_macros.svh"
module positional_array_list import pla_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pla_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pla_rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   // cells that a position field can address
   localparam int RD_N = (CAPACITY < POS_REACH) ? CAPACITY : POS_REACH;

   // list state and response register
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   pla_rsp_type      rsp_payload_ff;
   pla_rsp_type      rsp_payload_in;

   logic signed [DATA_W-1:0] cell_q [CAPACITY];
   pla_cmd_type              cmd;
   pla_act_type              act;
   pla_status_type           status;
   logic                     accept;
   logic                     full;
   logic [CW-1:0]            p;
   logic [CW-1:0]            q;
   logic [CW-1:0]            c;
   logic signed [DATA_W-1:0] rd_a;
   logic signed [DATA_W-1:0] rd_b;

   // handshake: stall only while a response waits under back-pressure
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   assign act  = pla_act_type'(req_payload.action);
   assign p    = CW'(req_payload.position);
   assign q    = CW'(req_payload.second_position);
   assign c    = CW'(count_ff);
   assign full = (count_ff == CNT_W'(CAPACITY));

   // read ports over the addressable cells
   always_comb begin
      rd_a = '0;
      rd_b = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (req_payload.position == POS_W'(i)) rd_a = cell_q[i];
         if (req_payload.second_position == POS_W'(i)) rd_b = cell_q[i];
      end
   end

   // status decode
   always_comb begin
      status = ST_OK;
      case (act)
         ACT_APPEND: if (full) status = ST_FULL;
         ACT_INSERT: begin
            if (p > c) status = ST_RANGE;
            else if (full) status = ST_FULL;
         end
         ACT_REMOVE: if (p >= c) status = ST_RANGE;
         ACT_SWAP:   if (p >= c || q >= c) status = ST_RANGE;
         ACT_READ:   if (p >= c) status = ST_RANGE;
         default:    status = ST_OK;
      endcase
   end

   // command broadcast to the cells and next count
   always_comb begin
      cmd.commit = accept && (status == ST_OK);
      cmd.act    = act;
      cmd.pos    = req_payload.position;
      cmd.pos2   = req_payload.second_position;
      cmd.value  = req_payload.value;
      cmd.val_a  = rd_a;
      cmd.val_b  = rd_b;

      count_in = count_ff;
      if (cmd.commit) begin
         case (act)
            ACT_APPEND: count_in = count_ff + CNT_W'(1);
            ACT_INSERT: count_in = count_ff + CNT_W'(1);
            ACT_REMOVE: count_in = count_ff - CNT_W'(1);
            default:    count_in = count_ff;
         endcase
      end
   end

   // response capture: hold while stalled
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_payload_in.read_value =
            (act == ACT_READ && status == ST_OK) ? rd_a : '0;
         rsp_payload_in.element_count = CNT_OUT_W'(count_in);
         rsp_payload_in.status        = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // row of cells, each wired to its neighbours
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] prev_w;
      logic signed [DATA_W-1:0] next_w;
      if (g == 0) begin : g_first
         assign prev_w = req_payload.value;
      end else begin : g_mid_lo
         assign prev_w = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_w = cell_q[g];
      end else begin : g_mid_hi
         assign next_w = cell_q[g+1];
      end
      pla_cell #(
         .CNT_W (CNT_W),
         .IDX   (g)
      ) u_cell (
         .clock   (clock),
         .cmd_i   (cmd),
         .count_i (count_ff),
         .prev_i  (prev_w),
         .next_i  (next_w),
         .entry_o (cell_q[g])
      );
   end

   // checks
   `PLA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PLA_ASSERT_NEXT(a_full_holds, clock, reset, accept && status == ST_FULL, $stable(count_ff))
   `PLA_ASSERT_NEXT(a_append_grows, clock, reset, cmd.commit && act == ACT_APPEND, count_ff == $past(count_ff) + CNT_W'(1))
   `PLA_ASSERT_SAME(a_stall_only_held, clock, reset, req_stall, rsp_valid_ff)

endmodule

[tb/tb_positional_array_list.sv]
`timescale 1ns / 1ps
// self-checking testbench for the positional array list: directed table then random requests
// depends on pla_pkg and positional_array_list; checks every response against its own list model
module tb_positional_array_list;
   import pla_pkg::*;

   localparam int CAPACITY = 16;
   // action codes that the block has no name for, it must ignore them
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
   // response hold-off that forces the block to stall its request side
   localparam int HOLD_CYCLES = 40;
   // cycles with no handshake on either side before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   // cap on printed mismatch lines, every mismatch is still counted
   localparam int REPORT_CAP = 50;
   localparam bit PINNED = 1'b1;
   localparam bit PREDICTED = 1'b0;

   // one line of the directed table: the request, how often to send it and,
   // where it is obvious, the response typed in by hand
   typedef struct {
      pla_req_type req;
      int unsigned reps;
      bit          pinned;
      pla_rsp_type rsp;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pla_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   pla_rsp_type rsp_payload;

   // hand-typed response travelling alongside the request being offered
   bit          pin_rsp_on;
   pla_rsp_type pin_rsp;

   // shadow of the list contents, updated at every accepted request
   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int                       list_len;
   pla_rsp_type              owed_rsp_q [$];
   script_row_type           script [$];

   // stimulus knobs, flipped by the main sequence
   bit grow;
   bit send_idle_on;
   bit stall_on;
   bit hold_pending;

   int unsigned mismatch_count;
   int unsigned req_seen;
   int unsigned rsp_seen;
   int unsigned n_full;
   int unsigned n_range;
   int unsigned n_reads;
   int unsigned peak_len;
   int unsigned quiet_cycles;

   positional_array_list #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // list behaviour: applies one request to the shadow list and gives its response
   function automatic pla_rsp_type apply_to_list(input pla_req_type r);
      pla_rsp_type              o;
      int                       i;
      logic signed [DATA_W-1:0] tmp;
      o = '0;
      case (r.action)
         ACT_APPEND: begin
            if (list_len >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               list_mem[list_len] = r.value;
               list_len++;
            end
         end
         ACT_INSERT: begin
            // range is checked before fullness
            if (r.position > list_len) begin
               o.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (i = list_len; i > r.position; i--) list_mem[i] = list_mem[i-1];
               list_mem[r.position] = r.value;
               list_len++;
            end
         end
         ACT_REMOVE: begin
            if (r.position >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               for (i = r.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         ACT_SWAP: begin
            if (r.position >= list_len || r.second_position >= list_len) begin
               o.status = ST_RANGE;
            end else begin
               tmp = list_mem[r.position];
               list_mem[r.position] = list_mem[r.second_position];
               list_mem[r.second_position] = tmp;
            end
         end
         ACT_READ: begin
            if (r.position >= list_len) o.status = ST_RANGE;
            else o.read_value = list_mem[r.position];
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      o.element_count = CNT_OUT_W'(list_len);
      return o;
   endfunction

   function automatic script_row_type mk(input logic [2:0] act, input logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] pos2,
                                         input logic [DATA_W-1:0] val,
                                         input int unsigned reps,
                                         input bit pinned, input logic [DATA_W-1:0] rd,
                                         input logic [CNT_OUT_W-1:0] cnt,
                                         input logic [1:0] st);
      script_row_type row;
      row.req.action = act;
      row.req.position = pos;
      row.req.second_position = pos2;
      row.req.value = val;
      row.reps = reps;
      row.pinned = pinned;
      row.rsp.read_value = rd;
      row.rsp.element_count = cnt;
      row.rsp.status = st;
      return row;
   endfunction

   // random request shaped by the current fill level: mostly positions the list
   // can take, a tenth of them pure noise, a few spare action codes
   function automatic pla_req_type random_request();
      pla_req_type r;
      int unsigned k;
      k = $urandom_range(99);
      r.position = POS_W'($urandom);
      r.second_position = POS_W'($urandom);
      r.value = $urandom;
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: r.value = 32'h7fff_ffff;
            1: r.value = 32'h8000_0000;
            2: r.value = '0;
            default: r.value = '1;
         endcase
      end
      if (k < 6) r.action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
      else if (k < 36) r.action = grow ? ACT_APPEND : ACT_REMOVE;
      else if (k < 56) r.action = ACT_INSERT;
      else if (k < 66) r.action = ACT_REMOVE;
      else if (k < 82) r.action = ACT_SWAP;
      else r.action = ACT_READ;
      if ($urandom_range(9) != 0) begin
         if (r.action == ACT_INSERT) begin
            // insert may also go at the end, one past the last entry
            r.position = POS_W'($urandom_range(list_len > CAPACITY - 1 ? CAPACITY - 1 : list_len));
         end else if (list_len > 0) begin
            r.position = POS_W'($urandom_range(list_len - 1));
            r.second_position = POS_W'($urandom_range(list_len - 1));
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("[%0t] response %0d: %s got %h, wanted %h", $time, rsp_seen, what, got, want);
   endtask

   // offer one request at the falling edge and hold it until it is taken
   task automatic offer(input pla_req_type r, input bit pinned, input pla_rsp_type want);
      if (send_idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_payload <= r;
      pin_rsp_on <= pinned;
      pin_rsp <= want;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // sender pauses until every request has been answered
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(negedge clock); while (owed_rsp_q.size() != 0);
   endtask

   task automatic random_burst(input int unsigned items);
      int unsigned k;
      for (k = 0; k < items; k++) begin
         // sweep the fill level up to full and back down to empty
         if (list_len == 0) grow = 1'b1;
         else if (list_len == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
         else if ($urandom_range(39) == 0) grow = !grow;
         offer(random_request(), PREDICTED, '0);
      end
   endtask

   // monitor: responses are checked before the request of the same edge is
   // predicted, a response can never belong to a request taken at that edge
   always @(posedge clock) begin : monitor
      pla_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (owed_rsp_q.size() == 0) begin
               report_mismatch("response with no request outstanding, read_value",
                               rsp_payload.read_value, '0);
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_payload.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_payload.read_value, want.read_value);
               if (rsp_payload.element_count !== want.element_count)
                  report_mismatch("element_count", DATA_W'(rsp_payload.element_count),
                                  DATA_W'(want.element_count));
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", DATA_W'(rsp_payload.status), DATA_W'(want.status));
            end
         end
         if (req_valid && !req_stall) begin
            req_seen++;
            want = apply_to_list(req_payload);
            if (pin_rsp_on) want = pin_rsp;
            owed_rsp_q.push_back(want);
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_RANGE) n_range++;
            if (req_payload.action == ACT_READ && want.status == ST_OK) n_reads++;
            if (list_len > peak_len) peak_len = list_len;
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("** positional_array_list: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random single-cycle stalls, plus one long hold-off on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= stall_on && ($urandom_range(99) < 11);
      end
   end

   initial begin : stimulus
      int unsigned n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      pin_rsp_on = 1'b0;
      pin_rsp = '0;
      list_len = 0;
      grow = 1'b1;
      send_idle_on = 1'b1;
      stall_on = 1'b1;
      hold_pending = 1'b0;

      // directed table: empty list, extremes, every action, refusals, full list
      script.push_back(mk(ACT_READ, 4'd0, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd0, ST_RANGE));
      script.push_back(mk(ACT_REMOVE, 4'd0, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd0, ST_RANGE));
      script.push_back(mk(ACT_SWAP, 4'd0, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd0, ST_RANGE));
      // insert past the end of an empty list
      script.push_back(mk(ACT_INSERT, 4'd1, 4'd0, 32'd123, 1, PINNED, 32'h0, 5'd0, ST_RANGE));
      script.push_back(mk(ACT_INSERT, 4'd0, 4'd0, 32'h7fff_ffff, 1, PINNED,
                          32'h0, 5'd1, ST_OK));
      script.push_back(mk(ACT_APPEND, 4'd0, 4'd0, 32'h8000_0000, 1, PINNED,
                          32'h0, 5'd2, ST_OK));
      script.push_back(mk(ACT_READ, 4'd1, 4'd0, 32'h0, 1, PINNED, 32'h8000_0000, 5'd2, ST_OK));
      script.push_back(mk(ACT_READ, 4'd0, 4'd0, 32'h0, 1, PINNED, 32'h7fff_ffff, 5'd2, ST_OK));
      // insert at the end position, then in the middle
      script.push_back(mk(ACT_INSERT, 4'd2, 4'd0, 32'hffff_ffff, 1, PINNED,
                          32'h0, 5'd3, ST_OK));
      script.push_back(mk(ACT_INSERT, 4'd1, 4'd0, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      script.push_back(mk(ACT_SWAP, 4'd0, 4'd3, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      // swap with itself
      script.push_back(mk(ACT_SWAP, 4'd2, 4'd2, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      // swap with either index past the end
      script.push_back(mk(ACT_SWAP, 4'd1, 4'd4, 32'h0, 1, PINNED, 32'h0, 5'd4, ST_RANGE));
      script.push_back(mk(ACT_SWAP, 4'd15, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd4, ST_RANGE));
      script.push_back(mk(ACT_SPARE_FIRST, 4'd15, 4'd15, 32'hffff_ffff, 1, PINNED,
                          32'h0, 5'd4, ST_OK));
      script.push_back(mk(ACT_SPARE_LAST, 4'd0, 4'd15, 32'h7fff_ffff, 1, PINNED,
                          32'h0, 5'd4, ST_OK));
      script.push_back(mk(ACT_READ, 4'd15, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd4, ST_RANGE));
      script.push_back(mk(ACT_REMOVE, 4'd4, 4'd0, 32'h0, 1, PINNED, 32'h0, 5'd4, ST_RANGE));
      script.push_back(mk(ACT_REMOVE, 4'd0, 4'd0, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      // fill to capacity
      script.push_back(mk(ACT_APPEND, 4'd0, 4'd0, 32'h5a5a_a5a5, 13, PREDICTED,
                          32'h0, 5'd0, ST_OK));
      script.push_back(mk(ACT_APPEND, 4'd0, 4'd0, 32'h1, 1, PINNED, 32'h0, 5'd16, ST_FULL));
      script.push_back(mk(ACT_INSERT, 4'd15, 4'd0, 32'h1, 1, PINNED, 32'h0, 5'd16, ST_FULL));
      script.push_back(mk(ACT_INSERT, 4'd0, 4'd0, 32'h1, 1, PINNED, 32'h0, 5'd16, ST_FULL));
      script.push_back(mk(ACT_READ, 4'd15, 4'd0, 32'h0, 1, PINNED, 32'h5a5a_a5a5, 5'd16, ST_OK));
      script.push_back(mk(ACT_SWAP, 4'd0, 4'd15, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      script.push_back(mk(ACT_REMOVE, 4'd15, 4'd0, 32'h0, 1, PREDICTED, 32'h0, 5'd0, ST_OK));
      script.push_back(mk(ACT_INSERT, 4'd15, 4'd0, 32'h1, 1, PREDICTED, 32'h0, 5'd0, ST_OK));

      // hold reset, then release it on a falling edge
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[s]) begin
         for (n = 0; n < script[s].reps; n++) offer(script[s].req, script[s].pinned, script[s].rsp);
      end
      wait_all_answered();

      // long response hold-off while requests keep coming, the block must back up
      hold_pending = 1'b1;
      random_burst(30);

      // random traffic with idling on both sides
      random_burst(280);

      // a stretch with no idling at all
      send_idle_on = 1'b0;
      stall_on = 1'b0;
      random_burst(200);
      send_idle_on = 1'b1;
      stall_on = 1'b1;
      wait_all_answered();

      random_burst(280);
      wait_all_answered();
      // idle on so that any stray response is still seen
      repeat (4) @(negedge clock);

      $display("covered %0d requests, %0d responses: %0d refused as full, %0d out of range",
               req_seen, rsp_seen, n_full, n_range);
      $display("%0d successful reads, list filled up to %0d of %0d entries",
               n_reads, peak_len, CAPACITY);
      if (mismatch_count == 0) begin
         $display("** positional_array_list: PASSED **");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("** positional_array_list: FAILED **");
      end
      $finish;
   end

endmodule
